@@ sv/jdhr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdhr_pkg
// Shared types and constants for the joystick direction decoder.
// ----------------------------------------------------------------------------
package jdhr_pkg;

    typedef enum logic [2:0] {
        DIR_CENTER = 3'd0,
        DIR_LEFT   = 3'd1,
        DIR_RIGHT  = 3'd2,
        DIR_DOWN   = 3'd3,
        DIR_UP     = 3'd4
    } dir_t;

    // classified item handed from front to back
    typedef struct packed {
        dir_t        act_dir;
        dir_t        rel_dir;
        logic [15:0] elapsed;
    } cls_t;

    localparam logic [2:0] REG_REST_X     = 3'd0;
    localparam logic [2:0] REG_REST_Y     = 3'd1;
    localparam logic [2:0] REG_ACT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_REL_LIMIT  = 3'd3;
    localparam logic [2:0] REG_DELAY      = 3'd4;
    localparam logic [2:0] REG_INTERVAL   = 3'd5;

    localparam logic [11:0] CENTER_RST    = 12'd2048;
    localparam logic [11:0] DEF_ACT       = 12'd900;
    localparam logic [11:0] DEF_REL       = 12'd500;
    localparam logic [15:0] DEF_DELAY     = 16'd350;
    localparam logic [15:0] DEF_INTERVAL  = 16'd140;
    localparam logic [11:0] MIN_ACT       = 12'd240;

    // span / 5 as (span * 0xCCCD) >> 18, exact for spans up to 16 bits
    localparam logic [15:0] DIV5_MUL      = 16'hCCCD;
    localparam int          DIV5_SHIFT    = 18;

    localparam int          QUEUE_DEPTH   = 2;

endpackage

@@ sv/joystick_direction_hysteresis_repeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_direction_hysteresis_repeat
// Four-direction joystick decoder with release hysteresis and auto-repeat.
//
//   channel   handshake                    payload
//   sample    sample_valid / sample_ready  sample_x, sample_y, elapsed
//   event     event_valid / event_ready    event_direction
//   config    APB psel/penable/pwrite      paddr, pwdata, prdata
//
// One item per cycle sustained while events are not stalled; event_valid rises
// once the sample has passed the classifier register, a queue entry, then the
// hold/repeat update into the event register.
// The hold/repeat update is a combinational read-modify-write of the timers, registered on each pop.
// A two-entry queue lets the classifier keep taking samples while events stall, until it fills.
// Reset restores all configuration registers to their defaults and the hold state to center.
// ----------------------------------------------------------------------------
module joystick_direction_hysteresis_repeat #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  logic [ADC_BITS-1:0] sample_x,
    input  logic [ADC_BITS-1:0] sample_y,
    input  logic [15:0]         elapsed,
    output logic                event_valid,
    input  logic                event_ready,
    output logic [2:0]          event_direction
);

    logic [11:0] rest_x_reg;
    logic [11:0] rest_y_reg;
    logic [11:0] act_lim_reg;
    logic [11:0] rel_lim_reg;
    logic [15:0] delay_reg;
    logic [15:0] intv_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    jdhr_pkg::cls_t push_item;
    jdhr_pkg::cls_t head_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_x_reg  <= jdhr_pkg::CENTER_RST;
            rest_y_reg  <= jdhr_pkg::CENTER_RST;
            act_lim_reg <= jdhr_pkg::DEF_ACT;
            rel_lim_reg <= jdhr_pkg::DEF_REL;
            delay_reg   <= jdhr_pkg::DEF_DELAY;
            intv_reg    <= jdhr_pkg::DEF_INTERVAL;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                jdhr_pkg::REG_REST_X:    rest_x_reg  <= pwdata[11:0];
                jdhr_pkg::REG_REST_Y:    rest_y_reg  <= pwdata[11:0];
                jdhr_pkg::REG_ACT_LIMIT: act_lim_reg <= pwdata[11:0];
                jdhr_pkg::REG_REL_LIMIT: rel_lim_reg <= pwdata[11:0];
                jdhr_pkg::REG_DELAY:     delay_reg   <= pwdata[15:0];
                jdhr_pkg::REG_INTERVAL:  intv_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            jdhr_pkg::REG_REST_X:    prdata = 32'(rest_x_reg);
            jdhr_pkg::REG_REST_Y:    prdata = 32'(rest_y_reg);
            jdhr_pkg::REG_ACT_LIMIT: prdata = 32'(act_lim_reg);
            jdhr_pkg::REG_REL_LIMIT: prdata = 32'(rel_lim_reg);
            jdhr_pkg::REG_DELAY:     prdata = 32'(delay_reg);
            jdhr_pkg::REG_INTERVAL:  prdata = 32'(intv_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    jdhr_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rest_x       (rest_x_reg),
        .rest_y       (rest_y_reg),
        .act_cap      (act_lim_reg),
        .rel_cap      (rel_lim_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .elapsed      (elapsed),
        .push         (push),
        .q_ready      (q_ready),
        .push_item    (push_item)
    );

    jdhr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_ready   (q_ready),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    jdhr_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .repeat_delay    (delay_reg),
        .repeat_interval (intv_reg),
        .q_valid         (q_valid),
        .pop             (pop),
        .head_item       (head_item),
        .event_valid     (event_valid),
        .event_ready     (event_ready),
        .event_direction (event_direction)
    );

endmodule

@@ sv/jdhr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdhr_front
// Classifier: thresholds and deviations, registered, then ratio compare.
// ----------------------------------------------------------------------------
module jdhr_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [11:0]          rest_x,
    input  logic [11:0]          rest_y,
    input  logic [11:0]          act_cap,
    input  logic [11:0]          rel_cap,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic [ADC_BITS-1:0]  sample_x,
    input  logic [ADC_BITS-1:0]  sample_y,
    input  logic [15:0]          elapsed,
    output logic                 push,
    input  logic                 q_ready,
    output jdhr_pkg::cls_t       push_item
);

    localparam int QW = (ADC_BITS > 12) ? ADC_BITS : 12;
    localparam int PW = ADC_BITS + 16;
    localparam int MW = ADC_BITS + 12;
    localparam logic [ADC_BITS-1:0] AMAX = {ADC_BITS{1'b1}};

    function automatic logic [23:0] side_thr(input logic [ADC_BITS-1:0] span,
                                             input logic [11:0] la,
                                             input logic [11:0] lr);
        logic [PW-1:0] prod;
        logic [QW-1:0] q;
        logic [11:0]   r;
        prod = PW'(span) * PW'(jdhr_pkg::DIV5_MUL);
        q = QW'(prod >> jdhr_pkg::DIV5_SHIFT);
        if (q < QW'(jdhr_pkg::MIN_ACT))
        begin
            q = QW'(jdhr_pkg::MIN_ACT);
        end
        if (q > QW'(la))
        begin
            q = QW'(la);
        end
        r = q[11:0] >> 1;
        if (r > lr)
        begin
            r = lr;
        end
        return {q[11:0], r};
    endfunction

    function automatic jdhr_pkg::dir_t classify(input logic [ADC_BITS-1:0] ax,
                                                input logic [ADC_BITS-1:0] ay,
                                                input logic xneg,
                                                input logic yneg,
                                                input logic [11:0] tx,
                                                input logic [11:0] ty);
        logic          xa;
        logic          ya;
        logic [MW-1:0] px;
        logic [MW-1:0] py;
        jdhr_pkg::dir_t d;
        xa = QW'(ax) >= QW'(tx);
        ya = QW'(ay) >= QW'(ty);
        px = MW'(ax) * MW'(ty);
        py = MW'(ay) * MW'(tx);
        if (!xa && !ya)
        begin
            d = jdhr_pkg::DIR_CENTER;
        end
        else if (xa && (!ya || px >= py))
        begin
            d = xneg ? jdhr_pkg::DIR_LEFT : jdhr_pkg::DIR_RIGHT;
        end
        else
        begin
            d = yneg ? jdhr_pkg::DIR_DOWN : jdhr_pkg::DIR_UP;
        end
        return d;
    endfunction

    logic [ADC_BITS-1:0] cx;
    logic [ADC_BITS-1:0] cy;
    logic [11:0]         lim_a;
    logic [11:0]         lim_r;
    logic                xneg;
    logic                yneg;
    logic [23:0]         thr_x;
    logic [23:0]         thr_y;
    logic                s1_load;

    logic                s1_valid_reg;
    logic [ADC_BITS-1:0] ax_reg;
    logic [ADC_BITS-1:0] ay_reg;
    logic                xneg_reg;
    logic                yneg_reg;
    logic [23:0]         thr_x_reg;
    logic [23:0]         thr_y_reg;
    logic [15:0]         el_reg;

    assign cx    = ADC_BITS'(rest_x);
    assign cy    = ADC_BITS'(rest_y);
    assign lim_a = (act_cap == 12'd0) ? jdhr_pkg::DEF_ACT : act_cap;
    assign lim_r = (rel_cap == 12'd0) ? jdhr_pkg::DEF_REL : rel_cap;
    assign xneg  = sample_x < cx;
    assign yneg  = sample_y < cy;
    assign thr_x = side_thr(xneg ? cx : AMAX - cx, lim_a, lim_r);
    assign thr_y = side_thr(yneg ? cy : AMAX - cy, lim_a, lim_r);

    assign sample_ready = !s1_valid_reg || q_ready;
    assign s1_load      = sample_valid && sample_ready;
    assign push         = s1_valid_reg && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            ax_reg    <= xneg ? cx - sample_x : sample_x - cx;
            ay_reg    <= yneg ? cy - sample_y : sample_y - cy;
            xneg_reg  <= xneg;
            yneg_reg  <= yneg;
            thr_x_reg <= thr_x;
            thr_y_reg <= thr_y;
            el_reg    <= elapsed;
        end
    end

    always_comb
    begin
        push_item.act_dir = classify(ax_reg, ay_reg, xneg_reg, yneg_reg,
                                     thr_x_reg[23:12], thr_y_reg[23:12]);
        push_item.rel_dir = classify(ax_reg, ay_reg, xneg_reg, yneg_reg,
                                     thr_x_reg[11:0], thr_y_reg[11:0]);
        push_item.elapsed = el_reg;
    end

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !q_ready |=> s1_valid_reg && $stable(el_reg))
        else $error("front stage dropped an item while the queue was full");

endmodule

@@ sv/jdhr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdhr_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module jdhr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            q_ready,
    input  jdhr_pkg::cls_t  push_item,
    input  logic            pop,
    output logic            q_valid,
    output jdhr_pkg::cls_t  head_item
);

    localparam int AW = (jdhr_pkg::QUEUE_DEPTH > 1) ? $clog2(jdhr_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(jdhr_pkg::QUEUE_DEPTH + 1);

    jdhr_pkg::cls_t mem [jdhr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(jdhr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign q_ready   = count_reg < CW'(jdhr_pkg::QUEUE_DEPTH);
    assign q_valid   = count_reg != '0;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'(jdhr_pkg::QUEUE_DEPTH) && !pop |=> count_reg == $past(count_reg))
        else $error("queue count moved past its depth");

endmodule

@@ sv/jdhr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdhr_back
// Hold, release, switch and auto-repeat tracking with the output register.
// ----------------------------------------------------------------------------
module jdhr_back #(
    parameter int TIME_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     repeat_delay,
    input  logic [15:0]     repeat_interval,
    input  logic            q_valid,
    output logic            pop,
    input  jdhr_pkg::cls_t  head_item,
    output logic            event_valid,
    input  logic            event_ready,
    output logic [2:0]      event_direction
);

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    jdhr_pkg::dir_t       held_reg;
    jdhr_pkg::dir_t       held_next;
    logic [TIME_BITS-1:0] ht_reg;
    logic [TIME_BITS-1:0] ht_next;
    logic [TIME_BITS-1:0] nr_reg;
    logic [TIME_BITS-1:0] nr_next;
    logic                 ev_valid_reg;
    jdhr_pkg::dir_t       ev_reg;
    jdhr_pkg::dir_t       ev_next;
    logic [TIME_BITS-1:0] delay_v;
    logic [TIME_BITS-1:0] intv_v;
    logic [TIME_BITS-1:0] ht_sum;

    assign delay_v = TIME_BITS'((repeat_delay == 16'd0) ? jdhr_pkg::DEF_DELAY : repeat_delay);
    assign intv_v  = TIME_BITS'((repeat_interval == 16'd0) ? jdhr_pkg::DEF_INTERVAL
                                                           : repeat_interval);
    assign ht_sum  = sat_add(ht_reg, TIME_BITS'(head_item.elapsed));

    assign pop             = q_valid && (!ev_valid_reg || event_ready);
    assign event_valid     = ev_valid_reg;
    assign event_direction = ev_reg;

    always_comb
    begin
        held_next = held_reg;
        ht_next   = ht_reg;
        nr_next   = nr_reg;
        ev_next   = jdhr_pkg::DIR_CENTER;
        if (head_item.elapsed == 16'd0)
        begin
            ev_next = jdhr_pkg::DIR_CENTER;
        end
        else if (held_reg == jdhr_pkg::DIR_CENTER)
        begin
            if (head_item.act_dir != jdhr_pkg::DIR_CENTER)
            begin
                held_next = head_item.act_dir;
                ht_next   = '0;
                nr_next   = delay_v;
                ev_next   = head_item.act_dir;
            end
        end
        else if (head_item.rel_dir == jdhr_pkg::DIR_CENTER)
        begin
            held_next = jdhr_pkg::DIR_CENTER;
            ht_next   = '0;
            nr_next   = '0;
        end
        else if (head_item.rel_dir != held_reg && head_item.act_dir != jdhr_pkg::DIR_CENTER
                 && head_item.act_dir != held_reg)
        begin
            held_next = head_item.act_dir;
            ht_next   = '0;
            nr_next   = delay_v;
            ev_next   = head_item.act_dir;
        end
        else
        begin
            ht_next = ht_sum;
            if (ht_sum >= nr_reg)
            begin
                nr_next = sat_add(nr_reg, intv_v);
                ev_next = held_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= jdhr_pkg::DIR_CENTER;
            ht_reg       <= '0;
            nr_reg       <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_reg <= held_next;
                ht_reg   <= ht_next;
                nr_reg   <= nr_next;
            end
            if (pop)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (event_ready)
            begin
                ev_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg <= ev_next;
        end
    end

    a_center_clear: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == jdhr_pkg::DIR_CENTER |-> ht_reg == '0 && nr_reg == '0)
        else $error("timers not cleared while centered");

    a_time_grows: assert property (@(posedge clk) disable iff (!rst_n)
        $stable(held_reg) |-> ht_reg >= $past(ht_reg))
        else $error("held time went backward while the direction was kept");

    a_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(held_reg) && $stable(nr_reg))
        else $error("hold state changed without an item");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick direction decoder. Samples are
// driven over valid/ready, events are compared in order against a local
// model of thresholds, hysteresis and auto-repeat. Runs a directed table,
// then gesture-shaped random samples over several register settings and
// flow-control mixes, with one long back-pressure hold and a long held
// direction with large time steps.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 70;
    localparam int PRESSURE_PHASE = 6;
    localparam int SAT_PHASE      = PHASES;
    localparam int SAT_ITEMS      = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PIPE_DRAIN     = 8;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DIRECTED_N     = 24;

    localparam logic [11:0] ADC_FULL         = 12'hFFF;
    localparam logic [11:0] SPAN_DIV         = 12'd5;
    localparam logic [11:0] ACT_FLOOR        = 12'd240;
    localparam logic [11:0] ACT_DEFAULT      = 12'd900;
    localparam logic [11:0] REL_DEFAULT      = 12'd500;
    localparam logic [15:0] DELAY_DEFAULT    = 16'd350;
    localparam logic [15:0] INTERVAL_DEFAULT = 16'd140;

    typedef struct packed {
        logic [11:0]    x;
        logic [11:0]    y;
        logic [15:0]    el;
        logic           typed;
        jdhr_pkg::dir_t want;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    logic [11:0] sample_x = '0;
    logic [11:0] sample_y = '0;
    logic [15:0] elapsed = '0;
    logic        event_valid;
    logic        event_ready = 1'b0;
    logic [2:0]  event_direction;

    // local copy of registers and hold state
    logic [11:0]    cfg_cx;
    logic [11:0]    cfg_cy;
    logic [11:0]    cfg_act;
    logic [11:0]    cfg_rel;
    logic [15:0]    cfg_delay;
    logic [15:0]    cfg_interval;
    jdhr_pkg::dir_t held_dir;
    logic [31:0]    held_ms;
    logic [31:0]    next_rep_ms;

    jdhr_pkg::dir_t event_q[$];
    jdhr_pkg::dir_t due_dir;

    int  errors = 0;
    int  items_sent = 0;
    int  events_checked = 0;
    int  quiet = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    int  g_left = 0;
    int  g_axis = 0;
    int  g_sign = 1;
    int  g_mag = 0;

    sample_row_t directed_rows [DIRECTED_N] = '{
        '{12'd2048, 12'd2048, 16'd10,    1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd0,    12'd2048, 16'd10,    1'b1, jdhr_pkg::DIR_LEFT},
        '{12'd0,    12'd2048, 16'd0,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd0,    12'd2048, 16'd400,   1'b1, jdhr_pkg::DIR_LEFT},
        '{12'd0,    12'd2048, 16'd100,   1'b0, jdhr_pkg::DIR_CENTER},
        '{12'd4095, 12'd2048, 16'd10,    1'b1, jdhr_pkg::DIR_RIGHT},
        '{12'd2048, 12'd2048, 16'd10,    1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd2048, 12'd4095, 16'd1,     1'b1, jdhr_pkg::DIR_UP},
        '{12'd2048, 12'd0,    16'd1,     1'b1, jdhr_pkg::DIR_DOWN},
        '{12'd2048, 12'd2048, 16'd1,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd4095, 12'd4095, 16'd1,     1'b1, jdhr_pkg::DIR_RIGHT},
        '{12'd2048, 12'd2048, 16'd1,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd0,    12'd0,    16'd65535, 1'b1, jdhr_pkg::DIR_LEFT},
        '{12'd0,    12'd0,    16'd65535, 1'b1, jdhr_pkg::DIR_LEFT},
        '{12'd0,    12'd0,    16'd65535, 1'b0, jdhr_pkg::DIR_CENTER},
        '{12'd2348, 12'd2048, 16'd5,     1'b0, jdhr_pkg::DIR_CENTER},
        '{12'd2148, 12'd2048, 16'd5,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd2048, 12'd2457, 16'd1,     1'b1, jdhr_pkg::DIR_UP},
        '{12'd2048, 12'd2456, 16'd1,     1'b0, jdhr_pkg::DIR_CENTER},
        '{12'd2048, 12'd2048, 16'd1,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd4095, 12'd0,    16'd1,     1'b0, jdhr_pkg::DIR_CENTER},
        '{12'd2048, 12'd2048, 16'd1,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd0,    12'd4095, 16'd0,     1'b1, jdhr_pkg::DIR_CENTER},
        '{12'd2048, 12'd2048, 16'd65535, 1'b1, jdhr_pkg::DIR_CENTER}
    };

    joystick_direction_hysteresis_repeat uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample_x        (sample_x),
        .sample_y        (sample_y),
        .elapsed         (elapsed),
        .event_valid     (event_valid),
        .event_ready     (event_ready),
        .event_direction (event_direction)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [11:0] act_threshold(input logic [11:0] span);
        logic [11:0] lim;
        logic [11:0] t;
        lim = (cfg_act == 12'd0) ? ACT_DEFAULT : cfg_act;
        t = span / SPAN_DIV;
        if (t < ACT_FLOOR)
            t = ACT_FLOOR;
        if (t > lim)
            t = lim;
        return t;
    endfunction

    function automatic logic [11:0] side_threshold(input logic [11:0] span, input bit rel);
        logic [11:0] lim;
        logic [11:0] half;
        lim = (cfg_rel == 12'd0) ? REL_DEFAULT : cfg_rel;
        half = act_threshold(span) >> 1;
        if (!rel)
            return act_threshold(span);
        return (half > lim) ? lim : half;
    endfunction

    function automatic jdhr_pkg::dir_t classify(input logic [11:0] x, input logic [11:0] y,
                                                input bit rel);
        bit          xneg;
        bit          yneg;
        bit          xa;
        bit          ya;
        logic [11:0] ax;
        logic [11:0] ay;
        logic [11:0] tx;
        logic [11:0] ty;
        xneg = x < cfg_cx;
        yneg = y < cfg_cy;
        ax = xneg ? cfg_cx - x : x - cfg_cx;
        ay = yneg ? cfg_cy - y : y - cfg_cy;
        tx = side_threshold(xneg ? cfg_cx : ADC_FULL - cfg_cx, rel);
        ty = side_threshold(yneg ? cfg_cy : ADC_FULL - cfg_cy, rel);
        xa = ax >= tx;
        ya = ay >= ty;
        if (!xa && !ya)
            return jdhr_pkg::DIR_CENTER;
        if (xa && (!ya || 32'(ax) * 32'(ty) >= 32'(ay) * 32'(tx)))
            return xneg ? jdhr_pkg::DIR_LEFT : jdhr_pkg::DIR_RIGHT;
        return yneg ? jdhr_pkg::DIR_DOWN : jdhr_pkg::DIR_UP;
    endfunction

    function automatic jdhr_pkg::dir_t next_event(input logic [11:0] x, input logic [11:0] y,
                                                  input logic [15:0] el);
        jdhr_pkg::dir_t cand;
        jdhr_pkg::dir_t act;
        logic [31:0]    dly;
        logic [31:0]    ivl;
        dly = {16'd0, (cfg_delay == 16'd0) ? DELAY_DEFAULT : cfg_delay};
        ivl = {16'd0, (cfg_interval == 16'd0) ? INTERVAL_DEFAULT : cfg_interval};
        if (el == 16'd0)
            return jdhr_pkg::DIR_CENTER;
        if (held_dir == jdhr_pkg::DIR_CENTER)
        begin
            cand = classify(x, y, 1'b0);
            if (cand != jdhr_pkg::DIR_CENTER)
            begin
                held_dir = cand;
                held_ms = '0;
                next_rep_ms = dly;
            end
            return cand;
        end
        cand = classify(x, y, 1'b1);
        if (cand == jdhr_pkg::DIR_CENTER)
        begin
            held_dir = jdhr_pkg::DIR_CENTER;
            held_ms = '0;
            next_rep_ms = '0;
            return jdhr_pkg::DIR_CENTER;
        end
        if (cand != held_dir)
        begin
            act = classify(x, y, 1'b0);
            if (act != jdhr_pkg::DIR_CENTER && act != held_dir)
            begin
                held_dir = act;
                held_ms = '0;
                next_rep_ms = dly;
                return act;
            end
        end
        held_ms = sat_add(held_ms, {16'd0, el});
        if (held_ms >= next_rep_ms)
        begin
            next_rep_ms = sat_add(next_rep_ms, ivl);
            return held_dir;
        end
        return jdhr_pkg::DIR_CENTER;
    endfunction

    function automatic logic [11:0] clamp_adc(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return ADC_FULL;
        return v[11:0];
    endfunction

    task automatic reset_model();
        cfg_cx = 12'd2048;
        cfg_cy = 12'd2048;
        cfg_act = ACT_DEFAULT;
        cfg_rel = REL_DEFAULT;
        cfg_delay = DELAY_DEFAULT;
        cfg_interval = INTERVAL_DEFAULT;
        held_dir = jdhr_pkg::DIR_CENTER;
        held_ms = '0;
        next_rep_ms = '0;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            jdhr_pkg::REG_REST_X:    cfg_cx = val[11:0];
            jdhr_pkg::REG_REST_Y:    cfg_cy = val[11:0];
            jdhr_pkg::REG_ACT_LIMIT: cfg_act = val[11:0];
            jdhr_pkg::REG_REL_LIMIT: cfg_rel = val[11:0];
            jdhr_pkg::REG_DELAY:     cfg_delay = val[15:0];
            jdhr_pkg::REG_INTERVAL:  cfg_interval = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_config(input int p);
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] act;
        logic [11:0] rel;
        logic [15:0] dly;
        logic [15:0] ivl;
        logic [31:0] junk;
        junk = (p >= 5 && p != SAT_PHASE) ? $urandom() : 32'd0;
        case (p)
            0:
            begin
                cx = 12'd2048; cy = 12'd2048; act = 12'd900; rel = 12'd500;
                dly = 16'd350; ivl = 16'd140;
            end
            1:
            begin
                cx = 12'd0; cy = 12'd0; act = 12'd4095; rel = 12'd4095;
                dly = 16'd1; ivl = 16'd1;
            end
            2:
            begin
                cx = 12'd4095; cy = 12'd4095; act = 12'd1; rel = 12'd1;
                dly = 16'd65535; ivl = 16'd65535;
            end
            3:
            begin
                cx = 12'd4095; cy = 12'd0; act = 12'd0; rel = 12'd0;
                dly = 16'd0; ivl = 16'd0;
            end
            4:
            begin
                cx = 12'd2048; cy = 12'd2048; act = 12'd240; rel = 12'd120;
                dly = 16'd50; ivl = 16'd20;
            end
            SAT_PHASE:
            begin
                cx = 12'd2048; cy = 12'd2048; act = 12'd900; rel = 12'd500;
                dly = 16'd65535; ivl = 16'd65535;
            end
            default:
            begin
                cx = 12'($urandom());
                cy = 12'($urandom());
                act = 12'($urandom());
                rel = 12'($urandom());
                dly = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 400));
                ivl = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
            end
        endcase
        apb_write(jdhr_pkg::REG_REST_X, {junk[19:0], cx});
        apb_write(jdhr_pkg::REG_REST_Y, {junk[31:12], cy});
        apb_write(jdhr_pkg::REG_ACT_LIMIT, {junk[19:0], act});
        apb_write(jdhr_pkg::REG_REL_LIMIT, {junk[31:12], rel});
        apb_write(jdhr_pkg::REG_DELAY, {junk[15:0], dly});
        apb_write(jdhr_pkg::REG_INTERVAL, {junk[31:16], ivl});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic make_sample(output logic [11:0] x, output logic [11:0] y,
                               output logic [15:0] el);
        int pick;
        int main_dev;
        int side_dev;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            x = 12'($urandom());
            y = 12'($urandom());
        end
        else
        begin
            if (g_left == 0)
            begin
                g_left = $urandom_range(1, 12);
                g_axis = $urandom_range(0, 1);
                g_sign = ($urandom_range(0, 1) == 1) ? 1 : -1;
                g_mag = $urandom_range(150, 2100);
            end
            g_left--;
            // occasional dip toward center exercises release and hysteresis
            if ($urandom_range(0, 4) == 0)
                main_dev = $urandom_range(0, 500);
            else
                main_dev = g_mag + $urandom_range(0, 120);
            if ($urandom_range(0, 3) == 0)
                side_dev = $urandom_range(0, g_mag);
            else
                side_dev = $urandom_range(0, 200);
            if ($urandom_range(0, 1) == 1)
                side_dev = -side_dev;
            main_dev = main_dev * g_sign;
            if (g_axis == 0)
            begin
                x = clamp_adc(int'(cfg_cx) + main_dev);
                y = clamp_adc(int'(cfg_cy) + side_dev);
            end
            else
            begin
                x = clamp_adc(int'(cfg_cx) + side_dev);
                y = clamp_adc(int'(cfg_cy) + main_dev);
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            el = 16'd0;
        else if (pick < 12)
            el = 16'($urandom());
        else
            el = 16'($urandom_range(1, 150));
    endtask

    task automatic send_sample(input logic [11:0] x, input logic [11:0] y,
                               input logic [15:0] el, input bit typed,
                               input jdhr_pkg::dir_t typed_dir);
        jdhr_pkg::dir_t predicted;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_x <= x;
        sample_y <= y;
        elapsed <= el;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = next_event(x, y, el);
        event_q.push_back(typed ? typed_dir : predicted);
        items_sent++;
    endtask

    task automatic settle();
        while (event_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            event_ready <= 1'b0;
        end
        else
            event_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && event_valid && event_ready)
        begin
            if (event_q.size() == 0)
            begin
                errors++;
                $display("%0t: event with nothing expected: expected none, actual %0d",
                         $time, event_direction);
            end
            else
            begin
                due_dir = event_q.pop_front();
                events_checked++;
                if (event_direction !== due_dir)
                begin
                    errors++;
                    $display("%0t: event_direction mismatch: expected %0d (%s), actual %0d",
                             $time, due_dir, due_dir.name(), event_direction);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (sample_valid && sample_ready) || (event_valid && event_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d events outstanding",
                     $time, QUIET_LIMIT, event_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [11:0] gx;
        logic [11:0] gy;
        logic [15:0] gel;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].el,
                        directed_rows[i].typed, directed_rows[i].want);
        sample_valid <= 1'b0;
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            program_config(p);
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 88; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 88; end
                default: begin gap_pct = 6;  stall_pct = 6;  end
            endcase
            if (p == PRESSURE_PHASE)
            begin
                gap_pct = 0;
                stall_pct = 0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                make_sample(gx, gy, gel);
                send_sample(gx, gy, gel, 1'b0, jdhr_pkg::DIR_CENTER);
            end
            sample_valid <= 1'b0;
            settle();
        end

        // hold left with large steps so repeats follow long delays
        program_config(SAT_PHASE);
        gap_pct = 0;
        stall_pct = 0;
        for (int n = 0; n < SAT_ITEMS; n++)
            send_sample(12'd0, 12'd2048, 16'($urandom_range(60000, 65535)), 1'b0,
                        jdhr_pkg::DIR_CENTER);
        sample_valid <= 1'b0;
        settle();

        $display("Covered %0d samples and %0d events over %0d register settings,",
                 items_sent, events_checked, PHASES + 2);
        $display("including a long output hold and a held direction with large time steps.");
        if (errors == 0 && event_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
sv/jdhr_pkg.sv
sv/jdhr_front.sv
sv/jdhr_queue.sv
sv/jdhr_back.sv
sv/joystick_direction_hysteresis_repeat.sv
bench/testbench.sv
